FILE: src/sensor_frame_crc_check_and_scale_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame checker
// Immediate-consequence and next-cycle forms, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECK_AND_SCALE_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_SCALE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SFCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define SFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, codes and helper functions of the sensor frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scale factors and offsets, hundredths of a unit
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [16:0] WORD_FULL   = 17'd65535;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_A_BAD = 2'd1;
  localparam logic [1:0] STATUS_B_BAD = 2'd2;

  typedef enum logic [2:0] {
    POS_A_MSB,
    POS_A_LSB,
    POS_A_CRC,
    POS_B_MSB,
    POS_B_LSB,
    POS_B_CRC
  } frame_pos_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } frame_rec_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 17501 * 65536: split at bit 16, one correction
  function automatic logic [14:0] div_word_full(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = {1'b0, x[15:0]} + {2'b00, q0};
    if (r0 >= WORD_FULL) begin
      q0 = q0 + 15'd1;
    end
    return q0;
  endfunction

endpackage

`default_nettype wire

FILE: src/sensor_frame_crc_check_and_scale.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_and_scale
// Checks six-byte humidity/temperature replies and scales the two words.
// ----------------------------------------------------------------------------
// Takes one reply byte per transfer and, on every sixth byte, emits one result
// transfer with the CRC status, both raw words, temperature in 0.01 degC and
// humidity in 0.01 %RH. Input rate is one byte per cycle; s_tready drops only
// while the record queue (QUEUE_DEPTH frames) is full because the output side
// is stalled. When its sixth byte is taken, the record enters the queue; the
// scale stage then registers the two scale multiplies, and the divide by
// 65535, offset and clamp go into the output register. A CRC failure still
// yields a result built from the bytes as received; if both words fail,
// status reports the first word.
`default_nettype none

module sensor_frame_crc_check_and_scale #(
  parameter int QUEUE_DEPTH = sfcc_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // [1:0] status, [17:2] word_a, [33:18] word_b,
                                      // [48:34] temp_centi_c, [62:49] humid_centi_pct,
                                      // [63] zero
);
  import sfcc_pkg::*;

`include "sensor_frame_crc_check_and_scale_assert.svh"

  logic        in_accept;
  frame_rec_t  front_rec;
  logic        push;
  logic        q_full;
  logic        q_empty;
  frame_rec_t  q_rec;
  logic        back_ready;
  logic        pop;

  logic [1:0]         status;
  logic [15:0]        word_a;
  logic [15:0]        word_b;
  logic signed [14:0] temp_centi_c;
  logic [13:0]        humid_centi_pct;

  // front stalls only when a whole-frame record has nowhere to go
  assign s_tready  = !q_full;
  assign in_accept = s_tvalid && s_tready;
  assign pop       = !q_empty && back_ready;

  sfcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser[0]),
    .rec         (front_rec),
    .push        (push)
  );

  sfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_rec  (q_rec),
    .empty    (q_empty)
  );

  sfcc_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (!q_empty),
    .in_ready        (back_ready),
    .in_rec          (q_rec),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .status          (status),
    .word_a          (word_a),
    .word_b          (word_b),
    .temp_centi_c    (temp_centi_c),
    .humid_centi_pct (humid_centi_pct)
  );

  assign m_tdata = {1'b0, humid_centi_pct, temp_centi_c, word_b, word_a, status};

  // a finished frame must never be written into a full queue
  `SFCC_ASSERT_SAME(a_no_push_full, push, !q_full, "frame record pushed into full queue")
  // a pushed record is visible to the back end on the next cycle
  `SFCC_ASSERT_NEXT(a_push_seen, push, !q_empty, "queue empty after frame push")
  // humidity clamp holds on every delivered result
  `SFCC_ASSERT_SAME(a_hum_range, m_tvalid, humid_centi_pct <= HUM_MAX, "humidity above limit")

endmodule

`default_nettype wire

FILE: src/sfcc_front.sv
// ----------------------------------------------------------------------------
// sfcc_front
// Byte intake: frame position, CRC per word, word capture, status.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               frame_start,
  output sfcc_pkg::frame_rec_t    rec,
  output logic                    push
);
  import sfcc_pkg::*;

  frame_pos_t pos;
  frame_pos_t pos_cur;
  frame_pos_t pos_next;
  logic [7:0] crc;
  logic [7:0] crc_in;
  logic [7:0] crc_new;
  logic [15:0] word_a;
  logic [7:0] high_b;
  logic [7:0] low_b;
  logic       check_a_ok;

  // effective position of this byte; a start mark restarts the frame
  always_comb begin
    case (pos)
      POS_A_MSB, POS_A_LSB, POS_A_CRC,
      POS_B_MSB, POS_B_LSB, POS_B_CRC: pos_cur = pos;
      default:                         pos_cur = POS_A_MSB;
    endcase
    if (frame_start) begin
      pos_cur = POS_A_MSB;
    end
  end

  // next state
  always_comb begin
    case (pos_cur)
      POS_A_MSB: pos_next = POS_A_LSB;
      POS_A_LSB: pos_next = POS_A_CRC;
      POS_A_CRC: pos_next = POS_B_MSB;
      POS_B_MSB: pos_next = POS_B_LSB;
      POS_B_LSB: pos_next = POS_B_CRC;
      POS_B_CRC: pos_next = POS_A_MSB;
      default:   pos_next = POS_A_LSB;
    endcase
  end

  // outputs
  always_comb begin
    case (pos_cur)
      POS_A_MSB, POS_B_MSB: crc_in = CRC_INIT;
      default:              crc_in = crc;
    endcase
    crc_new = crc8_byte(crc_in, rx_byte);
    push    = accept && (pos_cur == POS_B_CRC);

    rec.word_a = word_a;
    rec.word_b = {high_b, low_b};
    if (!check_a_ok) begin
      rec.status = STATUS_A_BAD;
    end else if (crc != rx_byte) begin
      rec.status = STATUS_B_BAD;
    end else begin
      rec.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_A_MSB;
      crc        <= CRC_INIT;
      check_a_ok <= 1'b0;
      word_a     <= '0;
      high_b     <= '0;
      low_b      <= '0;
    end else if (accept) begin
      pos <= pos_next;
      case (pos_cur)
        POS_A_MSB: begin
          crc    <= crc_new;
          word_a <= {rx_byte, 8'h00};
        end
        POS_A_LSB: begin
          crc         <= crc_new;
          word_a[7:0] <= rx_byte;
        end
        POS_A_CRC: begin
          check_a_ok <= (crc == rx_byte);
          crc        <= CRC_INIT;
        end
        POS_B_MSB: begin
          crc    <= crc_new;
          high_b <= rx_byte;
        end
        POS_B_LSB: begin
          crc   <= crc_new;
          low_b <= rx_byte;
        end
        default: begin
          crc <= CRC_INIT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/sfcc_queue.sv
// ----------------------------------------------------------------------------
// sfcc_queue
// Small first-in first-out queue of checked frame records.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_queue #(
  parameter int DEPTH = sfcc_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sfcc_pkg::frame_rec_t push_rec,
  output logic                      full,
  input  wire logic                 pop,
  output sfcc_pkg::frame_rec_t      pop_rec,
  output logic                      empty
);
  import sfcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign pop_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/sfcc_scale.sv
// ----------------------------------------------------------------------------
// sfcc_scale
// Two-stage scaling pipeline: products, then divide, offset, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcc_scale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sfcc_pkg::frame_rec_t in_rec,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                status,
  output logic [15:0]               word_a,
  output logic [15:0]               word_b,
  output logic signed [14:0]        temp_centi_c,
  output logic [13:0]               humid_centi_pct
);
  import sfcc_pkg::*;

  logic        s1_valid;
  frame_rec_t  s1_rec;
  logic [30:0] s1_prod_t;
  logic [29:0] s1_prod_h;
  logic        s1_ready;
  logic        out_free;

  logic [14:0] q_t;
  logic [14:0] q_h;
  logic [15:0] t_wide;
  logic [13:0] h_val;

  assign out_free = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_free;
  assign in_ready = s1_ready;

  always_comb begin
    q_t    = div_word_full(s1_prod_t);
    q_h    = div_word_full({1'b0, s1_prod_h});
    t_wide = {1'b0, q_t} - TEMP_OFFSET;
    if (q_h[13:0] < HUM_OFFSET) begin
      h_val = '0;
    end else if (q_h[13:0] - HUM_OFFSET > HUM_MAX) begin
      h_val = HUM_MAX;
    end else begin
      h_val = q_h[13:0] - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // operands widened to the full product width
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_rec    <= in_rec;
      s1_prod_t <= {16'd0, TEMP_SPAN} * {15'd0, in_rec.word_a};
      s1_prod_h <= {16'd0, HUM_SPAN} * {14'd0, in_rec.word_b};
    end
    if (out_free && s1_valid) begin
      status          <= s1_rec.status;
      word_a          <= s1_rec.word_a;
      word_b          <= s1_rec.word_b;
      temp_centi_c    <= signed'(t_wide[14:0]);
      humid_centi_pct <= h_val;
    end
  end

endmodule

`default_nettype wire
